[design/hof_pkg.sv]
// shared constants and types for the hampel outlier filter
package hof_pkg;

  localparam int unsigned MaxWindowDef  = 15;
  localparam int unsigned SampleBitsDef = 32;

  localparam logic [1:0] RegEnable = 2'd0;
  localparam logic [1:0] RegWindow = 2'd1;
  localparam logic [1:0] RegSigma  = 2'd2;
  localparam logic [1:0] RegFloor  = 2'd3;

  typedef enum logic [2:0] {
    StIdle,
    StLoad,
    StSortMed,
    StLoadDev,
    StSortMad,
    StJudge,
    StOut
  } state_e;

  // control from the sequencer to the cell row
  typedef struct packed {
    logic load;
    logic load_dev;
    logic sort_odd;
    logic sort_even;
  } cell_ctrl_t;

endpackage

[design/hof_cell.sv]
// one cell of the sorting row: holds a key, compare-exchanges with its right neighbor
module hof_cell import hof_pkg::*; #(
  parameter int unsigned KeyBits = 32
) (
  input  logic               clk_i,
  input  cell_ctrl_t         ctrl_i,
  input  logic               phase_sel_i,
  input  logic               active_i,
  input  logic               right_active_i,
  input  logic [KeyBits-1:0] load_key_i,
  input  logic [KeyBits-1:0] med_key_i,
  input  logic [KeyBits-1:0] left_key_i,
  input  logic               left_swap_i,
  input  logic [KeyBits-1:0] right_key_i,
  output logic [KeyBits-1:0] key_o,
  output logic               swap_o
);

  logic [KeyBits-1:0] key_q, key_d;
  logic [KeyBits-1:0] dev;
  logic               pair_lead;

  // this cell leads a pair when its phase matches the active sort pass
  assign pair_lead = ((ctrl_i.sort_odd & phase_sel_i) | (ctrl_i.sort_even & ~phase_sel_i));
  assign swap_o    = pair_lead & active_i & right_active_i & (key_q > right_key_i);
  assign dev       = (key_q >= med_key_i) ? key_q - med_key_i : med_key_i - key_q;

  always_comb begin
    key_d = key_q;
    if (ctrl_i.load) begin
      key_d = load_key_i;
    end else if (ctrl_i.load_dev) begin
      key_d = dev;
    end else if (swap_o) begin
      key_d = right_key_i;
    end else if (left_swap_i) begin
      key_d = left_key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign key_o = key_q;

endmodule

[design/hof_row.sv]
// row of sorting cells that sorts its keys by odd-even transposition
module hof_row import hof_pkg::*; #(
  parameter int unsigned MaxWindow = MaxWindowDef,
  parameter int unsigned KeyBits   = 32
) (
  input  logic                          clk_i,
  input  cell_ctrl_t                    ctrl_i,
  input  logic [MaxWindow-1:0]          active_i,
  input  logic [MaxWindow-1:0][KeyBits-1:0] load_keys_i,
  input  logic [KeyBits-1:0]            med_key_i,
  output logic [MaxWindow-1:0][KeyBits-1:0] keys_o
);

  logic [MaxWindow:0]                  swap;
  logic [MaxWindow+1:0][KeyBits-1:0]   kx;

  assign kx[0]           = '0;
  assign kx[MaxWindow+1] = '0;
  assign swap[0]         = 1'b0;

  for (genvar g = 0; g < MaxWindow; g++) begin : g_cell
    logic ra;
    if (g == MaxWindow - 1) begin : g_last
      assign ra = 1'b0;
    end else begin : g_mid
      assign ra = active_i[g+1];
    end
    hof_cell #(.KeyBits(KeyBits)) u_cell (
      .clk_i          (clk_i),
      .ctrl_i         (ctrl_i),
      .phase_sel_i    (1'(g % 2)),
      .active_i       (active_i[g]),
      .right_active_i (ra),
      .load_key_i     (load_keys_i[g]),
      .med_key_i      (med_key_i),
      .left_key_i     (kx[g]),
      .left_swap_i    (swap[g]),
      .right_key_i    (kx[g+2]),
      .key_o          (kx[g+1]),
      .swap_o         (swap[g+1])
    );
    assign keys_o[g] = kx[g+1];
  end

endmodule

[design/hampel_outlier_filter_top.sv]
// hampel outlier filter: window store, sorting cell row, sequencer and apb registers
//
// input channel: sample_in_i with in_valid_i, held off by in_stall_o.
// output channel: sample_out_o and was_replaced_o with out_valid_o, held by out_stall_i.
// a word is taken when valid is high and stall is low at a rising edge.
// one word is handled at a time. a passed-through word (disabled, or window
// not yet full) is ready in the cycle after it is taken. a filtered word runs two
// odd-even sorts on the cell row, MaxWindow passes each, plus load and judge
// steps.
// the result sits in an output register; a new word is taken only once the
// previous result has left, so out_stall_i backs up through in_stall_o.
// reset clears the history and loads the register defaults (enabled,
// window 5, sigma 3.0, floor 0). any apb register write clears the history.
// the window store holds no reset; only entries written since a clear are used.
module hampel_outlier_filter_top import hof_pkg::*; #(
  parameter int unsigned MaxWindow  = MaxWindowDef,
  parameter int unsigned SampleBits = SampleBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [3:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [SampleBits-1:0] sample_in_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [SampleBits-1:0] sample_out_o,
  output logic                  was_replaced_o
);

  localparam int unsigned IdxBits = $clog2(MaxWindow + 1);
  localparam int unsigned CapWin  = (MaxWindow % 2 == 0) ? MaxWindow - 1 : MaxWindow;

  // registers
  logic        en_q;
  logic [3:0]  win_q;
  logic [15:0] sig_q;
  logic [30:0] floor_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q    <= 1'b1;
      win_q   <= 4'd5;
      sig_q   <= 16'd768;
      floor_q <= '0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        RegEnable: en_q    <= pwdata[0];
        RegWindow: win_q   <= pwdata[3:0];
        RegSigma:  sig_q   <= pwdata[15:0];
        RegFloor:  floor_q <= pwdata[30:0];
        default:   en_q    <= en_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegEnable: prdata = {31'd0, en_q};
      RegWindow: prdata = {28'd0, win_q};
      RegSigma:  prdata = {16'd0, sig_q};
      RegFloor:  prdata = {1'b0, floor_q};
      default:   prdata = '0;
    endcase
  end

  // effective window length
  logic [IdxBits-1:0] w_eff;
  always_comb begin
    logic [4:0] w;
    w = {1'b0, win_q};
    if (w < 5'd3) w = 5'd3;
    if (!w[0]) w = w + 5'd1;
    if (32'(w) > CapWin) w = 5'(CapWin);
    w_eff = IdxBits'(w);
  end
  logic [IdxBits-1:0] half_w;
  assign half_w = w_eff >> 1;

  // history
  logic [MaxWindow-1:0][SampleBits-1:0] store_q;
  logic [IdxBits-1:0] fill_q, fill_d, slot_q, slot_d;

  // sequencer
  state_e state_q, state_d;
  logic [IdxBits-1:0] cnt_q, cnt_d;
  logic [SampleBits-1:0] samp_q;
  logic [SampleBits-1:0] med_q;
  logic [SampleBits-1:0] dout_q, dout_d;
  logic rep_q, rep_d;
  logic ovalid_q, ovalid_d;
  logic take;
  cell_ctrl_t ctrl;

  logic [MaxWindow-1:0][SampleBits-1:0] row_keys, load_keys;
  logic [MaxWindow-1:0] active;
  logic [SampleBits-1:0] mid_key;

  assign in_stall_o  = (state_q != StIdle) | ovalid_q;
  assign take        = in_valid_i & ~in_stall_o;
  assign out_valid_o = ovalid_q;
  assign sample_out_o   = dout_q;
  assign was_replaced_o = rep_q;

  for (genvar g = 0; g < MaxWindow; g++) begin : g_keys
    assign load_keys[g] = {~store_q[g][SampleBits-1], store_q[g][SampleBits-2:0]};
    assign active[g]    = (IdxBits'(g) < w_eff);
  end
  assign mid_key = row_keys[half_w];

  hof_row #(.MaxWindow(MaxWindow), .KeyBits(SampleBits)) u_row (
    .clk_i       (clk_i),
    .ctrl_i      (ctrl),
    .active_i    (active),
    .load_keys_i (load_keys),
    .med_key_i   (med_q),
    .keys_o      (row_keys)
  );

  // judge: |d|*256 > sigma*mad, mad > floor
  logic [SampleBits-1:0] sk, dmag;
  logic [SampleBits+7:0] lhs;
  logic [SampleBits+15:0] rhs_q;
  logic mad_ok_q;
  assign sk   = {~samp_q[SampleBits-1], samp_q[SampleBits-2:0]};
  assign dmag = (sk >= med_q) ? sk - med_q : med_q - sk;
  assign lhs  = {dmag, 8'd0};

  always_ff @(posedge clk_i) begin
    if (state_q == StSortMad && cnt_q == '0) begin
      rhs_q    <= (SampleBits+16)'(mid_key) * (SampleBits+16)'(sig_q);
      mad_ok_q <= (SampleBits+1)'(mid_key) > (SampleBits+1)'(floor_q);
    end
  end

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    fill_d   = fill_q;
    slot_d   = slot_q;
    dout_d   = dout_q;
    rep_d    = rep_q;
    ovalid_d = ovalid_q;
    ctrl     = '0;
    if (ovalid_q && !out_stall_i) ovalid_d = 1'b0;
    case (state_q)
      StIdle: begin
        if (take) begin
          dout_d = sample_in_i;
          rep_d  = 1'b0;
          if (!en_q) begin
            ovalid_d = 1'b1;
          end else begin
            slot_d = (slot_q + 1'b1 >= w_eff) ? '0 : slot_q + 1'b1;
            if (slot_q >= w_eff) slot_d = (w_eff == 1) ? '0 : IdxBits'(1);
            if (fill_q < w_eff) fill_d = fill_q + 1'b1;
            if (fill_q >= w_eff - 1'b1) state_d = StLoad;
            else ovalid_d = 1'b1;
          end
        end
      end
      StLoad: begin
        ctrl.load = 1'b1;
        cnt_d     = IdxBits'(MaxWindow);
        state_d   = StSortMed;
      end
      StSortMed: begin
        ctrl.sort_odd  = cnt_q[0];
        ctrl.sort_even = ~cnt_q[0];
        if (cnt_q == '0) begin
          ctrl  = '0;
          state_d = StLoadDev;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      StLoadDev: begin
        ctrl.load_dev = 1'b1;
        cnt_d   = IdxBits'(MaxWindow);
        state_d = StSortMad;
      end
      StSortMad: begin
        ctrl.sort_odd  = cnt_q[0];
        ctrl.sort_even = ~cnt_q[0];
        if (cnt_q == '0) begin
          ctrl    = '0;
          state_d = StJudge;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      StJudge: begin
        if (mad_ok_q && ((SampleBits+16)'(lhs) > rhs_q)) begin
          dout_d = {~med_q[SampleBits-1], med_q[SampleBits-2:0]};
          rep_d  = 1'b1;
        end
        state_d = StOut;
      end
      StOut: begin
        ovalid_d = 1'b1;
        state_d  = StIdle;
      end
      default: state_d = StIdle;
    endcase
    if (cfg_wr) begin
      fill_d = '0;
      slot_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      cnt_q    <= '0;
      fill_q   <= '0;
      slot_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      fill_q   <= fill_d;
      slot_q   <= slot_d;
      ovalid_q <= ovalid_d;
    end
  end

  logic [IdxBits-1:0] wr_idx;
  assign wr_idx = (slot_q >= w_eff) ? '0 : slot_q;

  always_ff @(posedge clk_i) begin
    dout_q <= dout_d;
    rep_q  <= rep_d;
    if (take) samp_q <= sample_in_i;
    if (take && en_q) store_q[wr_idx] <= sample_in_i;
    if (state_q == StSortMed && cnt_q == '0) med_q <= mid_key;
  end

`ifndef NO_ASSERTIONS
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> !take) else $error("word taken while busy");
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q <= IdxBits'(CapWin))) else $error("fill count out of range");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && out_stall_i) |=> (ovalid_q && $stable(dout_q))) else $error("output lost");
  a_rep_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StJudge) |-> $past(state_q == StSortMad)) else $error("judge out of order");
`endif

endmodule

[sim/tb.sv]
// self-checking testbench for the hampel outlier filter top level
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hof_pkg::*;

  typedef struct packed {
    logic signed [31:0] sample;
    logic               replaced;
  } filt_word_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic signed [31:0] sample_in_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [31:0]        sample_out_o;
  logic               was_replaced_o;

  hampel_outlier_filter_top uut (.*);

  // filter model state
  logic               cfg_enable;
  logic [3:0]         cfg_window;
  logic [15:0]        cfg_sigma;
  logic [30:0]        cfg_floor;
  logic signed [31:0] hist [15];
  int                 fill_cnt, slot_idx;

  filt_word_t expected_words[$];
  int         errors = 0;
  bit         idle_on = 1'b1;
  int         long_hold = 0;
  int         quiet_cycles = 0;

  initial forever #5 clk_i = ~clk_i;

  function automatic int eff_window();
    int w;
    w = cfg_window;
    if (w < 3) w = 3;
    if (w % 2 == 0) w = w + 1;
    if (w > 15) w = 15;
    return w;
  endfunction

  function automatic filt_word_t predict_hampel(logic signed [31:0] s);
    filt_word_t r;
    int w, i, j;
    longint vals [15];
    longint devs [15];
    longint x, med, mad, d;
    r.sample = s;
    r.replaced = 1'b0;
    if (!cfg_enable) return r;
    w = eff_window();
    if (slot_idx >= w) slot_idx = 0;
    hist[slot_idx] = s;
    slot_idx = (slot_idx + 1 >= w) ? 0 : slot_idx + 1;
    if (fill_cnt < w) fill_cnt++;
    if (fill_cnt < w) return r;
    for (i = 0; i < w; i++) vals[i] = longint'(hist[i]);
    for (i = 1; i < w; i++) begin
      x = vals[i];
      j = i;
      while (j > 0 && vals[j-1] > x) begin
        vals[j] = vals[j-1];
        j--;
      end
      vals[j] = x;
    end
    med = vals[w/2];
    for (i = 0; i < w; i++) begin
      devs[i] = longint'(hist[i]) - med;
      if (devs[i] < 0) devs[i] = -devs[i];
    end
    for (i = 1; i < w; i++) begin
      x = devs[i];
      j = i;
      while (j > 0 && devs[j-1] > x) begin
        devs[j] = devs[j-1];
        j--;
      end
      devs[j] = x;
    end
    mad = devs[w/2];
    d = longint'(s) - med;
    if (d < 0) d = -d;
    if (mad > longint'(cfg_floor) && d * 256 > longint'(cfg_sigma) * mad) begin
      r.sample = med[31:0];
      r.replaced = 1'b1;
    end
    return r;
  endfunction

  // result checker and watchdog
  always @(posedge clk_i) begin
    filt_word_t e;
    logic       moved;
    if (rst_ni) begin
      moved = (in_valid_i && !in_stall_o) || (psel && penable) ||
              (out_valid_o && !out_stall_i);
      quiet_cycles <= moved ? 0 : quiet_cycles + 1;
      if (out_valid_o && !out_stall_i) begin
        if (expected_words.size() == 0) begin
          $error("unexpected word: sample_out %h", sample_out_o);
          errors++;
        end else begin
          e = expected_words[0];
          expected_words.delete(0);
          if (sample_out_o !== e.sample) begin
            $error("sample_out expected %h actual %h", e.sample, sample_out_o);
            errors++;
          end
          if (was_replaced_o !== e.replaced) begin
            $error("was_replaced expected %b actual %b", e.replaced, was_replaced_o);
            errors++;
          end
        end
      end
      if (quiet_cycles > 5000) begin
        $display("FAIL hampel_outlier_filter_top");
        $finish;
      end
    end
  end

  // receiver stall bursts and long hold
  initial begin
    int burst;
    burst = 0;
    forever begin
      @(posedge clk_i);
      if (long_hold > 0) begin
        long_hold--;
        out_stall_i <= 1'b1;
      end else if (burst > 0) begin
        burst--;
        out_stall_i <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 9) - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic send_word(logic signed [31:0] s);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    sample_in_i <= s;
    do @(posedge clk_i); while (in_stall_o);
    expected_words = {expected_words, predict_hampel(s)};
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    wait_drained();
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      RegEnable: cfg_enable = val[0];
      RegWindow: cfg_window = val[3:0];
      RegSigma:  cfg_sigma  = val[15:0];
      RegFloor:  cfg_floor  = val[30:0];
      default: ;
    endcase
    fill_cnt = 0;
    slot_idx = 0;
  endtask

  function automatic logic signed [31:0] rand_sample(logic signed [31:0] base);
    int k;
    k = $urandom_range(0, 19);
    if (k == 0) return $urandom;
    if (k < 3) return base + $signed($urandom) / 4;
    return base + $signed($urandom_range(0, 8191)) - 4096;
  endfunction

  task automatic test_defaults_and_extremes();
    send_word(32'sh7fffffff);
    send_word(32'sh80000000);
    send_word(32'sh00000000);
    send_word(-32'sd1);
    send_word(32'sd1);
    send_word(32'sh7fffffff);
    send_word(32'sh80000000);
    send_word(32'sd2);
  endtask

  task automatic test_outlier_cases();
    write_reg(RegWindow, 32'd3);
    send_word(32'sd100);
    send_word(32'sd100);
    send_word(32'sd100);
    send_word(32'sd9000);
    send_word(32'sd100);
    send_word(32'sd200);
    send_word(32'sd300);
    send_word(32'sh7fff0000);
    // zero multiplier: any nonzero deviation replaces while the mad is above the floor
    write_reg(RegSigma, 32'd0);
    send_word(32'sd10);
    send_word(32'sd20);
    send_word(32'sd40);
    send_word(32'sd41);
    write_reg(RegSigma, 32'hffffffff);
    write_reg(RegFloor, 32'hffffffff);
    send_word(32'sd0);
    send_word(32'sd5);
    send_word(-32'sd5);
    send_word(32'sh80000000);
  endtask

  task automatic test_disabled();
    write_reg(RegEnable, 32'h0);
    repeat (6) send_word($urandom);
    write_reg(RegEnable, 32'hffffffff);
  endtask

  task automatic test_random_settings();
    logic signed [31:0] base;
    int p, n;
    for (p = 0; p < 12; p++) begin
      write_reg(RegWindow, (p == 0) ? 32'd0 : (p == 1) ? 32'd15 : $urandom);
      write_reg(RegSigma, (p == 2) ? 32'd1 : (p == 3) ? 32'hffff : $urandom_range(128, 1024));
      write_reg(RegFloor, (p % 4 == 0) ? 32'd0 : (p == 5) ? 32'h7fffffff
                                         : $urandom_range(0, 3000));
      if (p == 7) write_reg(RegEnable, 32'd0);
      if (p == 8) write_reg(RegEnable, 32'd1);
      base = $urandom;
      for (n = 0; n < 28; n++) send_word(rand_sample(base));
    end
  endtask

  task automatic test_backpressure();
    logic signed [31:0] base;
    base = $urandom;
    long_hold = 300;
    repeat (20) send_word(rand_sample(base));
    wait_drained();
    repeat (10) send_word(rand_sample(base));
  endtask

  task automatic test_no_idle();
    logic signed [31:0] base;
    idle_on = 1'b0;
    base = $urandom;
    repeat (40) send_word(rand_sample(base));
  endtask

  initial begin
    cfg_enable = 1'b1;
    cfg_window = 4'd5;
    cfg_sigma  = 16'd768;
    cfg_floor  = '0;
    fill_cnt   = 0;
    slot_idx   = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_defaults_and_extremes();
    test_outlier_cases();
    test_disabled();
    test_random_settings();
    test_backpressure();
    test_no_idle();
    wait_drained();
    if (errors == 0) begin
      $display("PASS hampel_outlier_filter_top");
    end else begin
      $display("FAIL hampel_outlier_filter_top");
    end
    $finish;
  end

endmodule
